>>> rtl/dvtp_pkg.sv
package dvtp_pkg;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [2:0] REG_REPORT_PERIOD = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd1;
  localparam logic [2:0] REG_WINDOW_MODE   = 3'd2;
  localparam logic [2:0] REG_LOW_A         = 3'd3;
  localparam logic [2:0] REG_HIGH_A        = 3'd4;
  localparam logic [2:0] REG_LOW_B         = 3'd5;
  localparam logic [2:0] REG_HIGH_B        = 3'd6;

  // Window comparator modes; the remaining codes behave as off.
  localparam logic [2:0] WIN_OFF     = 3'd0;
  localparam logic [2:0] WIN_OUTSIDE = 3'd1;
  localparam logic [2:0] WIN_INSIDE  = 3'd2;
  localparam logic [2:0] WIN_BELOW   = 3'd3;
  localparam logic [2:0] WIN_ABOVE   = 3'd4;

  // Report kinds.
  localparam logic KIND_PERIOD    = 1'b0;
  localparam logic KIND_THRESHOLD = 1'b1;

  localparam logic [31:0] DEBOUNCE_RESET = 32'd100;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
  localparam logic [31:0] VALUE_MIN      = 32'h8000_0000;

  typedef struct packed {
    logic [31:0]        report_period;
    logic [31:0]        debounce_ticks;
    logic [2:0]         window_mode;
    logic signed [31:0] low_a;
    logic signed [31:0] high_a;
    logic signed [31:0] low_b;
    logic signed [31:0] high_b;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic               last;
  } result_t;

  // Results produced by one item: count is 0, 1 or 2, first in r0.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> rtl/dvtp_regs.sv
module dvtp_regs
  import dvtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg,
  output logic        arm
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Writing the mode or any bound re-arms the hold-off counter.
  assign arm = wr && (idx == REG_WINDOW_MODE || idx == REG_LOW_A || idx == REG_HIGH_A ||
                      idx == REG_LOW_B || idx == REG_HIGH_B);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.report_period  <= '0;
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.window_mode    <= WIN_OFF;
      cfg.low_a          <= '0;
      cfg.high_a         <= '0;
      cfg.low_b          <= '0;
      cfg.high_b         <= '0;
    end else if (wr) begin
      case (idx)
        REG_REPORT_PERIOD: cfg.report_period  <= pwdata;
        REG_DEBOUNCE:      cfg.debounce_ticks <= pwdata;
        REG_WINDOW_MODE:   cfg.window_mode    <= pwdata[2:0];
        REG_LOW_A:         cfg.low_a          <= pwdata;
        REG_HIGH_A:        cfg.high_a         <= pwdata;
        REG_LOW_B:         cfg.low_b          <= pwdata;
        REG_HIGH_B:        cfg.high_b         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REPORT_PERIOD: prdata = cfg.report_period;
      REG_DEBOUNCE:      prdata = cfg.debounce_ticks;
      REG_WINDOW_MODE:   prdata = {29'd0, cfg.window_mode};
      REG_LOW_A:         prdata = cfg.low_a;
      REG_HIGH_A:        prdata = cfg.high_a;
      REG_LOW_B:         prdata = cfg.low_b;
      REG_HIGH_B:        prdata = cfg.high_b;
      default:           prdata = '0;
    endcase
  end

endmodule

>>> rtl/dvtp_core.sv
module dvtp_core
  import dvtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               arm,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_calc,
  input  logic               in_msg,
  input  logic signed [31:0] in_sample,
  input  logic               room,
  output push_t              push
);

  // Input register.
  logic               s1_valid;
  logic               s1_calc;
  logic               s1_msg;
  logic signed [31:0] s1_sample;
  logic               s1_fire;

  // Channel state.
  logic signed [31:0] cur_a, cur_b;
  logic [31:0]        rep_a, rep_b;
  logic [31:0]        period_count, holdoff_count;
  logic               parity;

  // Values after the calculation tick.
  logic signed [31:0] a_c, b_c;
  logic [31:0]        per_c, hold_c;
  logic               win_hit, period_hit, thr_hit;
  result_t            res_p, res_t;

  assign s1_fire  = s1_valid && room;
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_calc   <= in_calc;
      s1_msg    <= in_msg;
      s1_sample <= in_sample;
    end
  end

  always_comb begin
    a_c    = (s1_calc && parity) ? s1_sample : cur_a;
    b_c    = (s1_calc && !parity) ? s1_sample : cur_b;
    per_c  = (s1_calc && period_count != COUNT_MAX) ? period_count + 32'd1 : period_count;
    hold_c = (s1_calc && holdoff_count != cfg.debounce_ticks) ? holdoff_count + 32'd1
                                                              : holdoff_count;
    case (cfg.window_mode)
      WIN_OUTSIDE: win_hit = a_c < cfg.low_a || a_c > cfg.high_a ||
                             b_c < cfg.low_b || b_c > cfg.high_b;
      WIN_INSIDE:  win_hit = a_c > cfg.low_a && a_c < cfg.high_a &&
                             b_c > cfg.low_b && b_c < cfg.high_b;
      WIN_BELOW:   win_hit = a_c < cfg.low_a || b_c < cfg.low_b;
      WIN_ABOVE:   win_hit = a_c == VALUE_MIN || a_c > cfg.low_a ||
                             b_c == VALUE_MIN || b_c > cfg.low_b;
      default:     win_hit = 1'b0;
    endcase
    period_hit = s1_msg && cfg.report_period != '0 && per_c >= cfg.report_period &&
                 (rep_a != a_c || rep_b != b_c);
    thr_hit    = s1_msg && win_hit && hold_c == cfg.debounce_ticks;

    res_p = '{kind: KIND_PERIOD, value_a: a_c, value_b: b_c, last: !thr_hit};
    res_t = '{kind: KIND_THRESHOLD, value_a: a_c, value_b: b_c, last: 1'b1};

    push.r0    = period_hit ? res_p : res_t;
    push.r1    = res_t;
    push.count = s1_fire ? ({1'b0, period_hit} + {1'b0, thr_hit}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_a         <= '0;
      cur_b         <= '0;
      rep_a         <= COUNT_MAX;
      rep_b         <= COUNT_MAX;
      period_count  <= '0;
      holdoff_count <= '0;
      parity        <= 1'b0;
    end else if (arm) begin
      holdoff_count <= cfg.debounce_ticks;
    end else if (s1_fire) begin
      cur_a         <= a_c;
      cur_b         <= b_c;
      parity        <= parity ^ s1_calc;
      period_count  <= period_hit ? 32'd0 : per_c;
      holdoff_count <= thr_hit ? 32'd0 : hold_c;
      if (period_hit) begin
        rep_a <= a_c;
        rep_b <= b_c;
      end
    end
  end

endmodule

>>> rtl/dvtp_fifo.sv
module dvtp_fifo
  import dvtp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr, wr_ptr1;
  logic [CW-1:0]   count;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr1   = ptr_inc(wr_ptr);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for the largest burst one item can produce.
  assign room      = count <= CW'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.count)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= ptr_inc(wr_ptr1);
        default: ;
      endcase
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

endmodule

>>> rtl/dual_value_threshold_period_reporter.sv
// Dual-value window comparator with hold-off and periodic value reports for one
// sensor channel. Each input item carries a sample and two flags: a calculation
// tick stores the sample into value one or value two by alternating parity and
// advances the period and hold-off counters; a message tick, taken after the
// calculation tick of the same item, may emit a periodic report and then a
// threshold report, so one item yields zero, one or two result items, the last
// of them marked by m_tlast. The block takes one input item per clock: an
// accepted item waits in the input register, its whole update (one sample mux,
// the counter increments and four signed compares) is combinational, and its
// results go into a four-entry result queue; the first result of an
// item is offered once the item leaves the input register. The item in the
// input register completes only while the queue has room for two results;
// otherwise it stays there and s_tready is low. The sustained rate is one item
// per cycle as long as the output side drains at least as many results as are
// produced; each output item is shown from a registered queue entry, and
// results leave at one per cycle while m_tready is high. Configuration
// registers sit on the APB port at byte addresses 0 (report_period), 4
// (debounce_ticks), 8 (window_mode), 12 to 24 (the four bounds); writing the
// mode or a bound sets the hold-off counter to the debounce setting.
// Configuration is meant to be written only while no item is in flight.
module dual_value_threshold_period_reporter
  import dvtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic [1:0]  s_tuser,   // [0] do_calc, [1] do_message
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] value_a, [63:32] value_b
  output logic        m_tuser,   // [0] report_kind
  output logic        m_tlast,   // last_report
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    arm;
  logic    room;
  push_t   push;
  result_t head;

  dvtp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .arm     (arm)
  );

  dvtp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .arm       (arm),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_calc   (s_tuser[0]),
    .in_msg    (s_tuser[1]),
    .in_sample (s_tdata),
    .room      (room),
    .push      (push)
  );

  dvtp_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  assign m_tdata = {head.value_b, head.value_a};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

>>> rtl/dvtp_checker.sv
module dvtp_checker
  import dvtp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  // A threshold report is always the final result of its item.
  a_thr_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_THRESHOLD |-> m_tlast)
    else $error("threshold report not marked last");

  // A periodic report that is not last is directly followed by its threshold report.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == KIND_THRESHOLD)
    else $error("second result of an item missing");

endmodule

bind dual_value_threshold_period_reporter dvtp_checker u_dvtp_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dvtp_pkg::*;

  // Cycles to let pass after the last expected report before the block is
  // treated as idle. An item that yields no report can still sit in the input
  // register.
  localparam int SETTLE_CYCLES = 16;
  // Random stimulus: 13 settings of 150 items each.
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS   = 150;
  localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
  // Register index past the end of the register map; writes to it are dropped.
  localparam logic [2:0] REG_NONE = 3'd7;

  // Mirror of the reporter: register copy, channel state and the queue of
  // reports that the block still owes.
  class report_scoreboard;
    logic [31:0]        period_cfg;
    logic [31:0]        debounce_cfg;
    logic [2:0]         mode_cfg;
    logic signed [31:0] low_a;
    logic signed [31:0] high_a;
    logic signed [31:0] low_b;
    logic signed [31:0] high_b;

    logic signed [31:0] cur_a;
    logic signed [31:0] cur_b;
    logic [31:0]        sent_a;
    logic [31:0]        sent_b;
    logic [31:0]        period_cnt;
    logic [31:0]        holdoff_cnt;
    logic               parity;

    result_t owed_q[$];
    int errors;
    int items;
    int period_reports;
    int threshold_reports;

    function new();
      period_cfg   = '0;
      debounce_cfg = DEBOUNCE_RESET;
      mode_cfg     = WIN_OFF;
      low_a        = '0;
      high_a       = '0;
      low_b        = '0;
      high_b       = '0;
      cur_a        = '0;
      cur_b        = '0;
      sent_a       = COUNT_MAX;
      sent_b       = COUNT_MAX;
      period_cnt   = '0;
      holdoff_cnt  = '0;
      parity       = 1'b0;
      errors       = 0;
      items        = 0;
      period_reports    = 0;
      threshold_reports = 0;
    endfunction

    // Any write to the mode or a bound re-arms the hold-off counter.
    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_REPORT_PERIOD: period_cfg = val;
        REG_DEBOUNCE:      debounce_cfg = val;
        REG_WINDOW_MODE:   mode_cfg = val[2:0];
        REG_LOW_A:         low_a = val;
        REG_HIGH_A:        high_a = val;
        REG_LOW_B:         low_b = val;
        REG_HIGH_B:        high_b = val;
        default: ;
      endcase
      if (idx >= REG_WINDOW_MODE && idx <= REG_HIGH_B)
        holdoff_cnt = debounce_cfg;
    endfunction

    function bit window_hit();
      case (mode_cfg)
        WIN_OUTSIDE: return cur_a < low_a || cur_a > high_a || cur_b < low_b || cur_b > high_b;
        WIN_INSIDE:  return cur_a > low_a && cur_a < high_a && cur_b > low_b && cur_b < high_b;
        WIN_BELOW:   return cur_a < low_a || cur_b < low_b;
        WIN_ABOVE:   return cur_a > low_a || cur_b > low_b ||
                            cur_a == VALUE_MIN || cur_b == VALUE_MIN;
        default:     return 1'b0;
      endcase
    endfunction

    function result_t make_report(logic kind);
      result_t r;
      r.kind    = kind;
      r.value_a = cur_a;
      r.value_b = cur_b;
      r.last    = 1'b0;
      return r;
    endfunction

    function void note_item(bit calc, bit msg, logic [31:0] sample);
      result_t made[$];
      items++;
      if (calc) begin
        if (parity) cur_a = sample;
        else cur_b = sample;
        parity = ~parity;
        if (period_cnt != COUNT_MAX) period_cnt = period_cnt + 1;
        if (holdoff_cnt != debounce_cfg) holdoff_cnt = holdoff_cnt + 1;
      end
      if (msg) begin
        if (period_cfg != 0 && period_cnt >= period_cfg &&
            (sent_a != cur_a || sent_b != cur_b)) begin
          made.push_back(make_report(KIND_PERIOD));
          period_cnt = '0;
          sent_a = cur_a;
          sent_b = cur_b;
        end
        if (window_hit() && holdoff_cnt == debounce_cfg) begin
          made.push_back(make_report(KIND_THRESHOLD));
          holdoff_cnt = '0;
        end
      end
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) owed_q.push_back(made[i]);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: report with none owed: kind %0d a %0d b %0d last %0d",
                 $time, got.kind, got.value_a, got.value_b, got.last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (want.kind == KIND_PERIOD) period_reports++;
      else threshold_reports++;
      if (got.kind !== want.kind) begin
        $display("%0t: report_kind expected %0d, got %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.value_a !== want.value_a) begin
        $display("%0t: value_a expected %0d, got %0d", $time, want.value_a, got.value_a);
        errors++;
      end
      if (got.value_b !== want.value_b) begin
        $display("%0t: value_b expected %0d, got %0d", $time, want.value_b, got.value_b);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_report expected %0d, got %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] sample
  logic [1:0]  s_tuser;   // [0] do_calc, [1] do_message
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // [31:0] value_a, [63:32] value_b
  logic        m_tuser;   // [0] report_kind
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  report_scoreboard sb;
  int  settings_used;
  // Pacing of the two sides; when set, that side never idles.
  bit  tx_no_gap;
  bit  rx_no_stall;
  int  rx_hold;

  dual_value_threshold_period_reporter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Report side. After each accepted report the receiver draws a stall and
  // holds tready low until counted down; with no stall drawn tready simply
  // stays high, so back-to-back reports drain at full rate.
  always @(posedge clk) begin : report_sink
    result_t got;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else if (m_tvalid && m_tready) begin
      got.kind    = m_tuser;
      got.value_a = m_tdata[31:0];
      got.value_b = m_tdata[63:32];
      got.last    = m_tlast;
      sb.check_result(got);
      rx_hold = rx_no_stall ? 0 : $urandom_range(0, 12);
      if (rx_hold != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (rx_hold == 0) m_tready <= 1'b1;
      else rx_hold = rx_hold - 1;
    end
  end

  // Presents one item after a random gap and waits for the handshake. The
  // valid is left high on return so that a following item with no gap goes
  // out on the very next cycle.
  task automatic send_item(bit calc, bit msg, logic [31:0] sample);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= {msg, calc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(calc, msg, sample);
  endtask

  // Stops the input side and waits until every owed report has come out and
  // any item that produced nothing has also left the pipeline.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, access cycle, then an idle state so that a
  // following write never lowers and raises psel in the same step.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the whole register set. When the debounce setting goes last the
  // hold-off counter keeps the value armed from the old setting, which covers
  // a counter sitting above a lowered debounce.
  task automatic set_config(logic [31:0] period, logic [31:0] debounce, logic [2:0] mode,
                            logic signed [31:0] la, logic signed [31:0] ha,
                            logic signed [31:0] lb, logic signed [31:0] hb,
                            bit debounce_last);
    settings_used++;
    write_reg(REG_REPORT_PERIOD, period);
    if (!debounce_last) write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_WINDOW_MODE, {29'd0, mode});
    write_reg(REG_LOW_A, la);
    write_reg(REG_HIGH_A, ha);
    write_reg(REG_LOW_B, lb);
    write_reg(REG_HIGH_B, hb);
    if (debounce_last) write_reg(REG_DEBOUNCE, debounce);
  endtask

  task automatic pick_pacing();
    int r;
    r = $urandom_range(0, 5);
    tx_no_gap   = (r == 1 || r == 3);
    rx_no_stall = (r == 2 || r == 3);
  endtask

  // Samples and bounds lean toward a narrow band around zero so that the
  // window compares flip often; the extremes and full-range values are mixed in.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2, 3:    return $urandom;
      default: return int'($urandom_range(0, 50)) - 25;
    endcase
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 7))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2:       return $urandom;
      default: return int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd1;
      2, 3:    return $urandom_range(2, 10);
      4:       return $urandom;
      default: return COUNT_MAX;
    endcase
  endfunction

  function automatic logic [31:0] pick_debounce();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      5:       return DEBOUNCE_RESET;
      6:       return $urandom;
      7:       return COUNT_MAX;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin
    int ph;
    logic [2:0] mode;

    sb = new();
    settings_used = 0;
    tx_no_gap   = 1'b0;
    rx_no_stall = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Settings after reset: reporting is off, so none of the three item
    // kinds (no tick, calculation only, message only) may yield a report.
    send_item(1'b0, 1'b0, VALUE_MAX);
    send_item(1'b1, 1'b0, VALUE_MIN);
    send_item(1'b0, 1'b1, 32'd0);
    drain();

    // Outside window with zero debounce and a period of one tick: the
    // extreme samples give both reports on the same item; a message without
    // a calculation tick suppresses the period report.
    set_config(32'd1, 32'd0, WIN_OUTSIDE, -10, 10, -10, 10, 1'b0);
    send_item(1'b1, 1'b1, VALUE_MAX);
    send_item(1'b1, 1'b1, VALUE_MIN);
    send_item(1'b0, 1'b1, 32'd0);
    send_item(1'b1, 1'b1, 32'd0);
    send_item(1'b1, 1'b1, COUNT_MAX);
    send_item(1'b0, 1'b1, 32'd5);
    drain();

    // Above mode with the comparison level at the top of the range: only a
    // value equal to the most negative number can trip it.
    set_config(32'd0, 32'd2, WIN_ABOVE, VALUE_MAX, 0, VALUE_MAX, 0, 1'b0);
    send_item(1'b1, 1'b0, 32'd5);
    send_item(1'b1, 1'b1, VALUE_MIN);
    send_item(1'b1, 1'b1, COUNT_MAX);
    send_item(1'b1, 1'b1, 32'd1);
    send_item(1'b0, 1'b1, 32'd0);
    drain();

    // Inside mode with full-range bounds on value one.
    set_config(32'd2, 32'd0, WIN_INSIDE, VALUE_MIN, VALUE_MAX, -3, 3, 1'b0);
    send_item(1'b1, 1'b1, 32'd0);
    send_item(1'b1, 1'b1, 32'd3);
    send_item(1'b1, 1'b1, -2);
    send_item(1'b0, 1'b1, 32'd0);
    drain();

    // An unused mode code behaves as off, and a write past the register map
    // changes nothing.
    write_reg(REG_WINDOW_MODE, 32'd6);
    write_reg(REG_NONE, COUNT_MAX);
    send_item(1'b1, 1'b1, VALUE_MIN);
    send_item(1'b0, 1'b1, 32'd0);
    drain();

    // Lowered debounce: the counter is armed at 50 and the setting then drops
    // to 3, so the counter sits above it and no threshold report may appear.
    write_reg(REG_DEBOUNCE, 32'd50);
    write_reg(REG_WINDOW_MODE, {29'd0, WIN_BELOW});
    write_reg(REG_LOW_A, 32'd100);
    write_reg(REG_DEBOUNCE, 32'd3);
    send_item(1'b1, 1'b1, -5);
    send_item(1'b1, 1'b1, -7);
    drain();

    // Writing a bound re-arms the counter at the new setting.
    write_reg(REG_HIGH_B, 32'd0);
    send_item(1'b0, 1'b1, 32'd0);
    send_item(1'b1, 1'b1, 32'd200);
    drain();

    // Random part: each phase picks fresh settings and pacing. Most items
    // carry a calculation tick so the counters move; about half carry a
    // message tick.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(0, 3) == 0) mode = 3'($urandom_range(0, 7));
      else mode = 3'($urandom_range(1, 4));
      set_config(pick_period(), pick_debounce(), mode, pick_bound(), pick_bound(),
                 pick_bound(), pick_bound(), $urandom_range(0, 3) == 0);
      pick_pacing();
      repeat (PHASE_ITEMS)
        send_item($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), pick_sample());
      drain();
    end

    $display("testbench: %0d input items under %0d register settings, all window modes",
             sb.items, settings_used);
    $display("testbench: %0d period and %0d threshold reports compared",
             sb.period_reports, sb.threshold_reports);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #1_500_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/dvtp_pkg.sv
rtl/dvtp_regs.sv
rtl/dvtp_core.sv
rtl/dvtp_fifo.sv
rtl/dual_value_threshold_period_reporter.sv
rtl/dvtp_checker.sv
sim/testbench.sv
